[src/prt_pkg.sv]
// ----------------------------------------------------------------------------
// Prescaled reload timer package
// Shared constants, register and select codes, and the structs that pass from
// the register file to the datapath and between the controller and datapath.
// ----------------------------------------------------------------------------
package prt_pkg;

	localparam int CYCLE_WIDTH = 8;
	localparam int DIV_W       = 16;
	localparam int ACCUM_W     = 11;
	localparam int TIMER_W     = 8;
	localparam int ACC_W       = ((CYCLE_WIDTH > 10) ? CYCLE_WIDTH : 10) + 1;
	localparam int REM_W       = ACC_W - 4;
	localparam int HEAD_W      = TIMER_W + 1;
	localparam int CMP_W       = (REM_W > HEAD_W) ? REM_W : HEAD_W;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = 4;

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_SELECT = 2'd1,
		REG_RELOAD = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLK_SEL_1024 = 2'd0,
		CLK_SEL_16   = 2'd1,
		CLK_SEL_64   = 2'd2,
		CLK_SEL_256  = 2'd3
	} clk_sel_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_COUNT = 1'b1
	} state_t;

	typedef struct packed {
		logic               enable;
		logic [1:0]         select;
		logic [TIMER_W-1:0] reload;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic done;
	} status_t;

	// Log2 of the prescale period for a select code.
	function automatic logic [3:0] period_shift(input logic [1:0] sel);
		logic [3:0] sh;
		unique case (clk_sel_t'(sel))
			CLK_SEL_1024: sh = 4'd10;
			CLK_SEL_16:   sh = 4'd4;
			CLK_SEL_64:   sh = 4'd6;
			CLK_SEL_256:  sh = 4'd8;
			default:      sh = 4'd10;
		endcase
		return sh;
	endfunction

	// Mask that keeps the remainder below one prescale period.
	function automatic logic [ACC_W-1:0] period_mask(input logic [1:0] sel);
		return ~({ACC_W{1'b1}} << period_shift(sel));
	endfunction

endpackage

[src/prescaled_reload_timer.sv]
// ----------------------------------------------------------------------------
// Prescaled reload timer
// Free-running divider with a prescaled 8-bit timer that reloads on overflow.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall  elapsed_cycles
//   out      out_valid/out_stall  divider_value, timer_value, timer_interrupt
//   config   APB psel/penable     paddr, pwdata, prdata
//
// A request is loaded, takes one count step per timer overflow it causes,
// then commits; the count loop handles one overflow per cycle in one adder.
// The next request is taken as soon as the result is in the output register.
// Reset clears all counters and registers; no clearing pass is needed.
// A stalled output holds the finished request until the slot frees up.
// ----------------------------------------------------------------------------
module prescaled_reload_timer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [prt_pkg::CYCLE_WIDTH-1:0]   elapsed_cycles,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [prt_pkg::TIMER_W-1:0]       divider_value,
	output logic [prt_pkg::TIMER_W-1:0]       timer_value,
	output logic                              timer_interrupt,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [prt_pkg::ADDR_W-1:0]        paddr,
	input  logic [prt_pkg::DATA_W-1:0]        pwdata,
	output logic [prt_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);

	prt_pkg::cfg_t    cfg;
	prt_pkg::cmd_t    cmd;
	prt_pkg::status_t status;

	prt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	prt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	prt_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.status          (status),
		.elapsed_cycles  (elapsed_cycles),
		.divider_value   (divider_value),
		.timer_value     (timer_value),
		.timer_interrupt (timer_interrupt)
	);

endmodule

[src/prt_regs.sv]
// ----------------------------------------------------------------------------
// Prescaled reload timer register file
// APB-style configuration registers for enable, period select and reload.
// ----------------------------------------------------------------------------
module prt_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [prt_pkg::ADDR_W-1:0]   paddr,
	input  logic [prt_pkg::DATA_W-1:0]   pwdata,
	output logic [prt_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output prt_pkg::cfg_t                cfg
);

	prt_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (prt_pkg::reg_idx_t'(paddr[3:2]))
				prt_pkg::REG_ENABLE: cfg_q.enable <= pwdata[0];
				prt_pkg::REG_SELECT: cfg_q.select <= pwdata[1:0];
				prt_pkg::REG_RELOAD: cfg_q.reload <= pwdata[prt_pkg::TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (prt_pkg::reg_idx_t'(paddr[3:2]))
			prt_pkg::REG_ENABLE: prdata[0]                    = cfg_q.enable;
			prt_pkg::REG_SELECT: prdata[1:0]                  = cfg_q.select;
			prt_pkg::REG_RELOAD: prdata[prt_pkg::TIMER_W-1:0] = cfg_q.reload;
			default: ;
		endcase
	end

endmodule

[src/prt_ctrl.sv]
// ----------------------------------------------------------------------------
// Prescaled reload timer controller
// Sequences one request: load, then one count step per timer wrap, then the
// commit into the output register.
// ----------------------------------------------------------------------------
module prt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  prt_pkg::status_t  status,
	output prt_pkg::cmd_t     cmd
);

	prt_pkg::state_t state_q;
	prt_pkg::state_t state_next;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			prt_pkg::ST_IDLE: begin
				if (in_valid) state_next = prt_pkg::ST_COUNT;
			end
			prt_pkg::ST_COUNT: begin
				if (status.done && slot_free) state_next = prt_pkg::ST_IDLE;
			end
			default: state_next = prt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			prt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			prt_pkg::ST_COUNT: begin
				cmd.step   = ~status.done;
				cmd.commit = status.done & slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= prt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/prt_dp.sv]
// ----------------------------------------------------------------------------
// Prescaled reload timer datapath
// Divider, prescale accumulator, timer counter and the output register.
// ----------------------------------------------------------------------------
module prt_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  prt_pkg::cfg_t                      cfg,
	input  prt_pkg::cmd_t                      cmd,
	output prt_pkg::status_t                   status,
	input  logic [prt_pkg::CYCLE_WIDTH-1:0]    elapsed_cycles,
	output logic [prt_pkg::TIMER_W-1:0]        divider_value,
	output logic [prt_pkg::TIMER_W-1:0]        timer_value,
	output logic                               timer_interrupt
);

	logic [prt_pkg::DIV_W-1:0]   divider_q;
	logic [prt_pkg::ACCUM_W-1:0] accum_q;
	logic [prt_pkg::TIMER_W-1:0] timer_q;
	logic [prt_pkg::REM_W-1:0]   rem_q;
	logic                        irq_q;
	logic [prt_pkg::TIMER_W-1:0] div_out_q;
	logic [prt_pkg::TIMER_W-1:0] timer_out_q;
	logic                        irq_out_q;

	logic [prt_pkg::ACC_W-1:0]   acc_sum;
	logic [prt_pkg::HEAD_W-1:0]  headroom;
	logic [prt_pkg::TIMER_W-1:0] timer_final;

	// The sum of the held remainder and the new cycles is split into whole
	// periods, counted down by the step loop, and the remainder kept.
	assign acc_sum = prt_pkg::ACC_W'(accum_q) + prt_pkg::ACC_W'(elapsed_cycles);

	// Increments the timer can take before it wraps.
	assign headroom    = prt_pkg::HEAD_W'(1 << prt_pkg::TIMER_W)
	                     - prt_pkg::HEAD_W'(timer_q);
	assign status.done = prt_pkg::CMP_W'(rem_q) < prt_pkg::CMP_W'(headroom);
	assign timer_final = timer_q + prt_pkg::TIMER_W'(rem_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_q <= '0;
			accum_q   <= '0;
			timer_q   <= '0;
		end else begin
			if (cmd.load) begin
				divider_q <= divider_q + prt_pkg::DIV_W'(elapsed_cycles);
				if (cfg.enable) begin
					accum_q <= prt_pkg::ACCUM_W'(acc_sum & prt_pkg::period_mask(cfg.select));
				end
			end else if (cmd.step) begin
				timer_q <= cfg.reload;
			end else if (cmd.commit) begin
				timer_q <= timer_final;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			irq_q       <= 1'b0;
			div_out_q   <= '0;
			timer_out_q <= '0;
			irq_out_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				irq_q <= 1'b0;
				if (cfg.enable) begin
					rem_q <= prt_pkg::REM_W'(acc_sum >> prt_pkg::period_shift(cfg.select));
				end else begin
					rem_q <= '0;
				end
			end else if (cmd.step) begin
				rem_q <= rem_q - prt_pkg::REM_W'(headroom);
				irq_q <= 1'b1;
			end
			if (cmd.commit) begin
				div_out_q   <= divider_q[prt_pkg::DIV_W-1 -: prt_pkg::TIMER_W];
				timer_out_q <= timer_final;
				irq_out_q   <= irq_q;
			end
		end
	end

	assign divider_value   = div_out_q;
	assign timer_value     = timer_out_q;
	assign timer_interrupt = irq_out_q;

endmodule
